// ===== rtl/cscm_pkg.sv =====
`timescale 1ns / 1ps
package cscm_pkg;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;

  localparam logic signed [15:0] DEPTH_MAX = 16'sh7fff;
  localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;

  typedef enum logic [2:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_PATTERN_LEN  = 3'd2,
    CFG_SQUOTE_MODE  = 3'd3,
    CFG_DQUOTE_MODE  = 3'd4,
    CFG_COMMENT_MODE = 3'd5,
    CFG_PAREN_MODE   = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ANY     = 2'd0,
    MODE_INSIDE  = 2'd1,
    MODE_OUTSIDE = 2'd2,
    MODE_NEVER   = 2'd3
  } filter_mode_e;

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_STEP,
    ST_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       newline;
  } cscm_item_t;

  typedef struct packed {
    logic [127:0] pattern;
    logic [4:0]   pattern_length;
    logic [1:0]   squote_mode;
    logic [1:0]   dquote_mode;
    logic [1:0]   comment_mode;
    logic [1:0]   paren_mode;
  } cscm_cfg_t;

  function automatic logic filter_ok(input logic [1:0] mode, input logic active);
    logic ok;
    unique case (filter_mode_e'(mode))
      MODE_ANY:     ok = 1'b1;
      MODE_INSIDE:  ok = active;
      MODE_OUTSIDE: ok = !active;
      default:      ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic signed [15:0] sat_step(input logic signed [15:0] v,
                                                  input logic up, input logic down);
    logic signed [15:0] r;
    r = v;
    if (up && v != DEPTH_MAX) r = v + 16'sd1;
    if (down && v != DEPTH_MIN) r = v - 16'sd1;
    return r;
  endfunction

endpackage

// ===== rtl/cscm_if.sv =====
`timescale 1ns / 1ps
interface cscm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface cscm_line_if #(parameter int LINE_NUMBER_BITS = 24);
  logic                        valid;
  logic                        ready;
  logic [LINE_NUMBER_BITS-1:0] line_number;
  logic                        line_matched;
  modport source (output valid, output line_number, output line_matched, input ready);
  modport sink (input valid, input line_number, input line_matched, output ready);
endinterface

interface cscm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cscm_front.sv =====
`timescale 1ns / 1ps
module cscm_front
  import cscm_pkg::*;
(
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] text_byte_i,
  output logic       push_o,
  output cscm_item_t item_o,
  input  logic       full_i
);

  assign ready_o = !full_i;
  assign push_o = valid_i && !full_i;
  assign item_o.text_byte = text_byte_i;
  assign item_o.newline = (text_byte_i == CH_NL);

endmodule

// ===== rtl/cscm_queue.sv =====
`timescale 1ns / 1ps
module cscm_queue
  import cscm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cscm_item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output cscm_item_t item_o,
  input  logic       pop_i
);

  cscm_item_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o = mem_q[rd_q];

  always_comb begin
    wr_d = push_i ? !wr_q : wr_q;
    rd_d = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ===== rtl/cscm_back.sv =====
`timescale 1ns / 1ps
module cscm_back
  import cscm_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int LINE_NUMBER_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cscm_cfg_t                   cfg_i,
  input  logic                        q_valid_i,
  input  cscm_item_t                  q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [LINE_NUMBER_BITS-1:0] line_number_o,
  output logic                        line_matched_o
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = {LINE_NUMBER_BITS{1'b1}};
  localparam logic [5:0] MAX6 = 6'(MAX_PATTERN);

  back_state_e state_q, state_d;
  logic [7:0]  win_q [MAX_PATTERN];
  logic [7:0]  win_d [MAX_PATTERN];
  logic [7:0]  sh    [MAX_PATTERN];
  logic [7:0]  p1_q, p1_d, p2_q, p2_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        sq_q, sq_d, dq_q, dq_d, match_q, match_d;
  logic signed [15:0] cdep_q, cdep_d, pdep_q, pdep_d;
  logic [LINE_NUMBER_BITS-1:0] line_q, line_d;
  logic        out_valid_q, out_valid_d, out_match_q, out_match_d;

  logic [5:0]  len6, need6, cnt6;
  logic [7:0]  c, nx;
  logic        esc_ok, outside0, outside1, sq_n, dq_n, eq, judge, clear;
  logic signed [15:0] pdep_n, cdep_n;

  always_comb begin
    len6 = {1'b0, cfg_i.pattern_length};
    if (len6 == 6'd0) len6 = 6'd1;
    else if (len6 > MAX6) len6 = MAX6;
    need6 = (len6 < 6'd2) ? 6'd2 : len6;
    cnt6 = 6'(cnt_q);
  end

  // context update and match test for the oldest waiting position
  always_comb begin
    c = win_q[0];
    for (int k = 0; k < MAX_PATTERN; k++) begin
      sh[k] = (k + 1 < MAX_PATTERN) ? win_q[(k + 1) % MAX_PATTERN] : 8'h00;
    end
    nx = sh[0];
    esc_ok = (p1_q != CH_BSLASH) || (p2_q == CH_BSLASH);
    outside0 = !sq_q && !dq_q;
    pdep_n = sat_step(pdep_q, outside0 && cdep_q == 16'sd0 && c == CH_LPAREN,
                      outside0 && cdep_q == 16'sd0 && c == CH_RPAREN);
    sq_n = (cdep_q == 16'sd0 && c == CH_SQUOTE && esc_ok) ? !sq_q : sq_q;
    dq_n = (cdep_q == 16'sd0 && c == CH_DQUOTE && esc_ok) ? !dq_q : dq_q;
    outside1 = !sq_n && !dq_n;
    cdep_n = sat_step(cdep_q, outside1 && c == CH_SLASH && nx == CH_STAR,
                      outside1 && c == CH_STAR && nx == CH_SLASH);
    eq = (cnt6 >= len6);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (6'(k) < len6 && win_q[k] != cfg_i.pattern[8*k +: 8]) eq = 1'b0;
    end
    eq = eq && filter_ok(cfg_i.squote_mode, sq_n) && filter_ok(cfg_i.dquote_mode, dq_n)
         && filter_ok(cfg_i.comment_mode, cdep_n != 16'sd0)
         && filter_ok(cfg_i.paren_mode, pdep_n != 16'sd0);
  end

  always_comb begin
    state_d = state_q;
    win_d = win_q;
    p1_d = p1_q;
    p2_d = p2_q;
    cnt_d = cnt_q;
    sq_d = sq_q;
    dq_d = dq_q;
    match_d = match_q;
    cdep_d = cdep_q;
    pdep_d = pdep_q;
    line_d = line_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_match_d = out_match_q;
    q_pop_o = 1'b0;
    judge = 1'b0;
    clear = 1'b0;
    unique case (state_q)
      ST_TAKE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          if (cnt6 < MAX6) begin
            win_d[cnt_q[IDX_W-1:0]] = q_item_i.text_byte;
            cnt_d = cnt_q + 1'b1;
          end
          state_d = q_item_i.newline ? ST_FLUSH : ST_STEP;
        end
      end
      ST_STEP: begin
        judge = (cnt6 >= need6);
        state_d = ST_TAKE;
      end
      ST_FLUSH: begin
        if (cnt_q != '0) begin
          judge = 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          if (line_q != LINE_MAX) line_d = line_q + 1'b1;
          out_valid_d = 1'b1;
          out_match_d = match_q;
          clear = 1'b1;
          state_d = ST_TAKE;
        end
      end
      default: state_d = ST_TAKE;
    endcase
    if (judge) begin
      if (!match_q) begin
        pdep_d = pdep_n;
        cdep_d = cdep_n;
        sq_d = sq_n;
        dq_d = dq_n;
        match_d = eq;
      end
      p2_d = p1_q;
      p1_d = c;
      win_d = sh;
      cnt_d = cnt_q - 1'b1;
    end
    if (clear) begin
      for (int k = 0; k < MAX_PATTERN; k++) win_d[k] = 8'h00;
      p1_d = 8'h00;
      p2_d = 8'h00;
      cnt_d = '0;
      sq_d = 1'b0;
      dq_d = 1'b0;
      match_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKE;
      for (int k = 0; k < MAX_PATTERN; k++) win_q[k] <= 8'h00;
      p1_q <= 8'h00;
      p2_q <= 8'h00;
      cnt_q <= '0;
      sq_q <= 1'b0;
      dq_q <= 1'b0;
      match_q <= 1'b0;
      cdep_q <= 16'sd0;
      pdep_q <= 16'sd0;
      line_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q <= win_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      cnt_q <= cnt_d;
      sq_q <= sq_d;
      dq_q <= dq_d;
      match_q <= match_d;
      cdep_q <= cdep_d;
      pdep_q <= pdep_d;
      line_q <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_match_q <= out_match_d;
  end

  assign out_valid_o = out_valid_q;
  assign line_number_o = line_q;
  assign line_matched_o = out_match_q;

endmodule

// ===== rtl/c_context_string_match_unit.sv =====
`timescale 1ns / 1ps
// c source pattern matcher with lexical context filters
// text_i: one source byte per request; byte 10 closes the line
// line_o: one request per closed line with its number and a match flag
// cfg_i: register writes (index, data), always ready; write only while idle
// a front stage tags newlines and feeds a two-entry queue; the back end
// takes a byte, then judges at most one waiting position before it takes the next
// a newline is inserted, then each waiting position (up to the pattern
// length, at least two) is judged, then the output register is loaded
// throughput is set by the single judge unit
// the output register frees the back end once a result is loaded; while
// line_o stalls, the queue and back end keep taking bytes up to the next
// newline, and then text_i backs up
// reset clears depths, quote state, line count and config (pattern length 1)
module c_context_string_match_unit
  import cscm_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int LINE_NUMBER_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cscm_byte_if.sink    text_i,
  cscm_cfg_if.sink     cfg_i,
  cscm_line_if.source  line_o
);

  cscm_cfg_t  cfg_q;
  logic       push, full, q_valid, pop;
  cscm_item_t push_item, q_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.pattern_length <= 5'd1;
      cfg_q.squote_mode <= MODE_ANY;
      cfg_q.dquote_mode <= MODE_ANY;
      cfg_q.comment_mode <= MODE_ANY;
      cfg_q.paren_mode <= MODE_ANY;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PATTERN_LOW:  cfg_q.pattern[63:0] <= cfg_i.data;
        CFG_PATTERN_HIGH: cfg_q.pattern[127:64] <= cfg_i.data;
        CFG_PATTERN_LEN:  cfg_q.pattern_length <= cfg_i.data[4:0];
        CFG_SQUOTE_MODE:  cfg_q.squote_mode <= cfg_i.data[1:0];
        CFG_DQUOTE_MODE:  cfg_q.dquote_mode <= cfg_i.data[1:0];
        CFG_COMMENT_MODE: cfg_q.comment_mode <= cfg_i.data[1:0];
        CFG_PAREN_MODE:   cfg_q.paren_mode <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  cscm_front u_front (
    .valid_i     (text_i.valid),
    .ready_o     (text_i.ready),
    .text_byte_i (text_i.text_byte),
    .push_o      (push),
    .item_o      (push_item),
    .full_i      (full)
  );

  cscm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  cscm_back #(
    .MAX_PATTERN      (MAX_PATTERN),
    .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (pop),
    .out_valid_o    (line_o.valid),
    .out_ready_i    (line_o.ready),
    .line_number_o  (line_o.line_number),
    .line_matched_o (line_o.line_matched)
  );

endmodule
